FILE: design/aes3bm_pkg.sv
package aes3bm_pkg;

    localparam int SLOT_W  = 28;
    localparam int PRE_W   = 8;
    localparam int CELLS_W = PRE_W + 2 * SLOT_W;

    // Preamble codes reported with each subframe
    typedef enum logic [1:0] {
        PRE_KIND_Z = 2'd0,
        PRE_KIND_X = 2'd1,
        PRE_KIND_Y = 2'd2
    } pre_kind_t;

    // Preamble cell patterns for a line sitting low, first cell in the MSB
    localparam logic [PRE_W-1:0] PRE_Z_CELLS = 8'b1110_1000;
    localparam logic [PRE_W-1:0] PRE_X_CELLS = 8'b1110_0010;
    localparam logic [PRE_W-1:0] PRE_Y_CELLS = 8'b1110_0100;

    // Line state that one subframe starts from
    typedef struct packed {
        logic      level;
        pre_kind_t kind;
    } sf_ctx_t;

    function automatic logic [PRE_W-1:0] preamble_cells(input pre_kind_t kind,
                                                       input logic level);
        logic [PRE_W-1:0] pat;
        begin
            unique case (kind)
                PRE_KIND_Z: pat = PRE_Z_CELLS;
                PRE_KIND_X: pat = PRE_X_CELLS;
                PRE_KIND_Y: pat = PRE_Y_CELLS;
                default:    pat = PRE_Z_CELLS;
            endcase
            // invert when the line sits high
            return level ? ~pat : pat;
        end
    endfunction

endpackage

FILE: design/aes3_subframe_biphase_encoder_top.sv
// A subframe accepted on the slave side is registered in the input stage, then in
// the result register, from which it is offered on the master side.
// Throughput: one subframe per cycle while m_axis_tready holds; the line level and
// block counter update in the accept cycle, so back-to-back subframes never wait
// on each other.
// Reset (rst_n low, asynchronous): line level low, block counter at the Z preamble,
// both pipeline stages empty.
module aes3_subframe_biphase_encoder_top
    import aes3bm_pkg::*;
#(
    parameter int SUBFRAMES_PER_BLOCK = 384
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [27:0] slot_bits, [31:28] zero

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] cells
    output logic [1:0]  m_axis_tuser    // [1:0] preamble_kind
);

    localparam int CNT_W = $clog2(SUBFRAMES_PER_BLOCK);

    // Handshake control
    logic              in_xact;
    logic              s1_adv;

    // Input stage: slot bits plus the line context they start from
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [SLOT_W-1:0] s1_data_reg;
    sf_ctx_t           s1_ctx_reg;

    // Result stage
    logic               m_valid_reg;
    logic               m_valid_next;
    logic [CELLS_W-1:0] cells_reg;
    pre_kind_t          kind_reg;

    sf_ctx_t            cur_ctx;
    logic [CELLS_W-1:0] enc_cells;
    logic [SLOT_W-1:0]  in_slots;

    assign in_slots = s_axis_tdata[SLOT_W-1:0];

    // Advance the input stage whenever the result register is free or being
    // drained; take a new transaction whenever the input stage can advance.
    assign s1_adv        = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign in_xact       = s_axis_tvalid && s_axis_tready;

    // Line level and block position, stepped once per accepted subframe
    aes3bm_tracker #(
        .SUBFRAMES_PER_BLOCK (SUBFRAMES_PER_BLOCK),
        .CNT_W               (CNT_W)
    ) u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (in_xact),
        .slot_parity (^in_slots),
        .ctx         (cur_ctx)
    );

    // Biphase-mark expansion of the held subframe
    aes3bm_cell_enc u_cell_enc (
        .slot_bits (s1_data_reg),
        .ctx       (s1_ctx_reg),
        .cells     (enc_cells)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xact)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        m_valid_next = m_valid_reg;
        if (s1_adv)
            m_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers: capture on transaction, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_xact)
        begin
            s1_data_reg <= in_slots;
            s1_ctx_reg  <= cur_ctx;
        end
        if (s1_adv && s1_valid_reg)
        begin
            cells_reg <= enc_cells;
            kind_reg  <= s1_ctx_reg.kind;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = cells_reg;
    assign m_axis_tuser  = kind_reg;

    // A stalled result with a full input stage must block new transactions
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && m_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while both stages are full");

    // A subframe in the input stage moves to the result register when it frees
    a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_adv) |=> m_valid_reg)
        else $error("subframe dropped between stages");

endmodule

FILE: design/aes3bm_tracker.sv
module aes3bm_tracker
    import aes3bm_pkg::*;
#(
    parameter int SUBFRAMES_PER_BLOCK = 384,
    parameter int CNT_W               = 9
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  logic    slot_parity,
    output sf_ctx_t ctx
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             level_reg;
    logic             level_next;
    logic             last_in_block;

    assign last_in_block = (count_reg == CNT_W'(SUBFRAMES_PER_BLOCK - 1));

    always_comb
    begin
        count_next = count_reg;
        level_next = level_reg;
        if (advance)
        begin
            count_next = last_in_block ? '0 : count_reg + 1'b1;
            // 28 slots give an even number of clock transitions, so only
            // the ones move the line level at the end of the subframe
            level_next = level_reg ^ slot_parity;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            level_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            level_reg <= level_next;
        end
    end

    always_comb
    begin
        ctx.level = level_reg;
        if (count_reg == '0)
            ctx.kind = PRE_KIND_Z;
        else if (count_reg[0])
            ctx.kind = PRE_KIND_Y;
        else
            ctx.kind = PRE_KIND_X;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(SUBFRAMES_PER_BLOCK - 1))
        else $error("subframe count past block end");

    a_count_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && last_in_block) |=> (count_reg == '0))
        else $error("subframe count failed to wrap");

    a_level_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(level_reg))
        else $error("line level moved without a subframe");

endmodule

FILE: design/aes3bm_cell_enc.sv
module aes3bm_cell_enc
    import aes3bm_pkg::*;
(
    input  logic [SLOT_W-1:0]  slot_bits,
    input  sf_ctx_t            ctx,
    output logic [CELLS_W-1:0] cells
);

    logic [SLOT_W-1:0] lvl_before;

    // Level ahead of each slot: start level, flipped once per earlier slot
    // and once more per earlier one
    always_comb
    begin
        for (int k = 0; k < SLOT_W; k++)
        begin
            lvl_before[k] = ctx.level ^ 1'((SLOT_W - 1 - k) & 1)
                            ^ (^(slot_bits >> (k + 1)));
        end
    end

    always_comb
    begin
        cells[CELLS_W-1 -: PRE_W] = preamble_cells(ctx.kind, ctx.level);
        for (int k = 0; k < SLOT_W; k++)
        begin
            cells[2 * k + 1] = ~lvl_before[k];
            cells[2 * k]     = ~lvl_before[k] ^ slot_bits[k];
        end
    end

endmodule
